// ----- rtl/vpq_pkg.sv -----
// ----------------------------------------------------------------------------
// vpq_pkg: shared types and constants of the voice priority queue
// Holds the queue depth, field types, function and class codes, the
// class ranking, the search token that runs down the cell chain and the
// command that the controller issues to the cells.
// ----------------------------------------------------------------------------
package vpq_pkg;

    localparam int QueueDepth = 8;
    localparam int IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW       = $clog2(QueueDepth + 1);

    typedef logic [1:0]      func_t;
    typedef logic [9:0]      voice_t;
    typedef logic [7:0]      prio_t;
    typedef logic [2:0]      class_t;
    typedef logic [1:0]      rank_t;
    typedef logic [IdxW-1:0] idx_t;
    typedef logic [CntW-1:0] count_t;

    // Function codes
    localparam func_t FUNC_SUBMIT = 2'd0;
    localparam func_t FUNC_NEXT   = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    // Control classes
    localparam class_t CLASS_CRITICAL  = 3'd0;
    localparam class_t CLASS_QUEUED_IR = 3'd1;
    localparam class_t CLASS_INTERRUPT = 3'd2;
    localparam class_t CLASS_QUEUE     = 3'd3;
    localparam class_t CLASS_STANDARD  = 3'd4;

    // Rank levels, lower plays first
    localparam rank_t RANK_TOP    = 2'd0;
    localparam rank_t RANK_IRQ    = 2'd1;
    localparam rank_t RANK_QUEUE  = 2'd2;
    localparam rank_t RANK_BOTTOM = 2'd3;

    typedef struct packed {
        voice_t voice;
        prio_t  prio;
        class_t cls;
    } entry_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic   hit;
        logic   std_found;
        idx_t   std_idx;
        prio_t  std_prio;
        logic   any;
        idx_t   best_idx;
        rank_t  best_rank;
        prio_t  best_prio;
        voice_t best_voice;
        idx_t   worst_idx;
        rank_t  worst_rank;
        prio_t  worst_prio;
    } token_t;

    // Update command broadcast to all cells
    typedef struct packed {
        logic   load_en;
        idx_t   load_idx;
        logic   drop_en;
        idx_t   drop_idx;
        entry_t entry;
    } cmd_t;

    function automatic rank_t class_rank(input class_t c);
        rank_t r;
        case (c)
            CLASS_CRITICAL:  r = RANK_TOP;
            CLASS_QUEUED_IR: r = RANK_IRQ;
            CLASS_INTERRUPT: r = RANK_IRQ;
            CLASS_QUEUE:     r = RANK_QUEUE;
            default:         r = RANK_BOTTOM;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/vpq_if.sv -----
// ----------------------------------------------------------------------------
// vpq_if: request and response channels of the voice priority queue
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vpq_req_if;
    logic              valid;
    logic              ready;
    vpq_pkg::func_t    func;
    vpq_pkg::voice_t   voice_id;
    vpq_pkg::prio_t    priority_req;
    vpq_pkg::class_t   control_class;
    vpq_pkg::voice_t   playing_voice;

    modport source (
        output valid, func, voice_id, priority_req, control_class, playing_voice,
        input  ready
    );
    modport sink (
        input  valid, func, voice_id, priority_req, control_class, playing_voice,
        output ready
    );
endinterface

interface vpq_rsp_if;
    logic              valid;
    logic              ready;
    logic              cut_playing;
    logic              next_valid;
    vpq_pkg::voice_t   next_voice;

    modport source (
        output valid, cut_playing, next_valid, next_voice,
        input  ready
    );
    modport sink (
        input  valid, cut_playing, next_valid, next_voice,
        output ready
    );
endinterface

// ----- rtl/vpq_cell.sv -----
// ----------------------------------------------------------------------------
// vpq_cell: one queue slot of the voice priority queue
// Holds one entry, shifts in its upper neighbor on a drop, loads a new
// entry on an append, and folds its entry into the search token that it
// registers and hands to the next cell.
// ----------------------------------------------------------------------------
module vpq_cell (
    input  logic              clk,
    input  vpq_pkg::idx_t     my_idx,
    input  logic              valid,
    input  vpq_pkg::voice_t   key_voice,
    input  vpq_pkg::cmd_t     cmd,
    input  vpq_pkg::entry_t   nbr,
    input  vpq_pkg::token_t   tok_in,
    output vpq_pkg::entry_t   entry,
    output vpq_pkg::token_t   tok_out
);

    vpq_pkg::entry_t entry_reg;
    vpq_pkg::token_t tok_reg;
    vpq_pkg::token_t tok_next;
    vpq_pkg::rank_t  my_rank;

    assign my_rank = vpq_pkg::class_rank(entry_reg.cls);

    // Load a new entry, or take the neighbor's when this slot or a lower one drops
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && (cmd.load_idx == my_idx))
        begin
            entry_reg <= cmd.entry;
        end
        else if (cmd.drop_en && (my_idx >= cmd.drop_idx))
        begin
            entry_reg <= nbr;
        end
    end

    // Fold this slot into the search token
    always_comb
    begin
        tok_next = tok_in;
        if (valid)
        begin
            if (entry_reg.voice == key_voice)
            begin
                tok_next.hit = 1'b1;
            end
            if (!tok_in.std_found && (entry_reg.cls == vpq_pkg::CLASS_STANDARD))
            begin
                tok_next.std_found = 1'b1;
                tok_next.std_idx   = my_idx;
                tok_next.std_prio  = entry_reg.prio;
            end
            tok_next.any = 1'b1;
            if (!tok_in.any || (my_rank < tok_in.best_rank) ||
                ((my_rank == tok_in.best_rank) && (entry_reg.prio > tok_in.best_prio)))
            begin
                tok_next.best_idx   = my_idx;
                tok_next.best_rank  = my_rank;
                tok_next.best_prio  = entry_reg.prio;
                tok_next.best_voice = entry_reg.voice;
            end
            if (!tok_in.any || (my_rank > tok_in.worst_rank) ||
                ((my_rank == tok_in.worst_rank) && (entry_reg.prio < tok_in.worst_prio)))
            begin
                tok_next.worst_idx  = my_idx;
                tok_next.worst_rank = my_rank;
                tok_next.worst_prio = entry_reg.prio;
            end
        end
    end

    // Hand the token on to the next cell
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign entry   = entry_reg;
    assign tok_out = tok_reg;

endmodule

// ----- rtl/voice_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// voice_priority_queue_top: bounded priority queue of pending voice requests
// Sequence: on request accept the search token walks the cell chain one
// cell per cycle in ST_SCAN, then ST_DECIDE updates the queue and ST_RESP
// holds the response until the sink takes it.
// One request is in flight at a time: a new request is accepted only
// after the response has been taken.
// Reset: rst_n asynchronous, active low; empties the queue and drops any
// pending response. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module voice_priority_queue_top (
    input  logic clk,
    input  logic rst_n,
    vpq_req_if.sink   req,
    vpq_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_RESP
    } state_t;

    typedef struct packed {
        vpq_pkg::func_t  func;
        vpq_pkg::voice_t voice;
        vpq_pkg::prio_t  prio;
        vpq_pkg::class_t cls;
        vpq_pkg::voice_t play;
    } req_t;

    localparam vpq_pkg::idx_t ScanLast = vpq_pkg::idx_t'(vpq_pkg::QueueDepth - 1);

    state_t            state_reg;
    vpq_pkg::idx_t     scan_cnt_reg;
    vpq_pkg::count_t   count_reg;
    vpq_pkg::count_t   count_next;
    req_t              req_reg;
    logic              rsp_valid_reg;
    logic              cut_reg;
    logic              cut_next;
    logic              nvalid_reg;
    logic              nvalid_next;
    vpq_pkg::voice_t   nvoice_reg;
    vpq_pkg::voice_t   nvoice_next;
    vpq_pkg::cmd_t     cmd;
    vpq_pkg::token_t   tok_final;
    logic              go;

    vpq_pkg::entry_t   cell_entry [vpq_pkg::QueueDepth];
    vpq_pkg::token_t   cell_tok   [vpq_pkg::QueueDepth];

    assign req.ready = (state_reg == ST_IDLE);

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.func  <= req.func;
            req_reg.voice <= req.voice_id;
            req_reg.prio  <= req.priority_req;
            req_reg.cls   <= req.control_class;
            req_reg.play  <= req.playing_voice;
        end
    end

    // Cell chain
    genvar gi;
    generate
        for (gi = 0; gi < vpq_pkg::QueueDepth; gi++)
        begin : g_cell
            vpq_pkg::entry_t nbr;
            vpq_pkg::token_t tin;
            logic            slot_valid;

            if (gi == vpq_pkg::QueueDepth - 1)
            begin : g_last
                assign nbr = cell_entry[gi];
            end
            else
            begin : g_mid
                assign nbr = cell_entry[gi + 1];
            end

            if (gi == 0)
            begin : g_first
                assign tin = '0;
            end
            else
            begin : g_rest
                assign tin = cell_tok[gi - 1];
            end

            assign slot_valid = (vpq_pkg::count_t'(gi) < count_reg);

            vpq_cell u_cell (
                .clk       (clk),
                .my_idx    (vpq_pkg::idx_t'(gi)),
                .valid     (slot_valid),
                .key_voice (req_reg.voice),
                .cmd       (cmd),
                .nbr       (nbr),
                .tok_in    (tin),
                .entry     (cell_entry[gi]),
                .tok_out   (cell_tok[gi])
            );
        end
    endgenerate

    assign tok_final = cell_tok[vpq_pkg::QueueDepth - 1];

    // Decide the queue update and the response from the finished search
    always_comb
    begin
        vpq_pkg::count_t cnt_after;

        cnt_after       = count_reg;
        count_next      = count_reg;
        cut_next        = 1'b0;
        nvalid_next     = 1'b0;
        nvoice_next     = '0;
        cmd.load_en     = 1'b0;
        cmd.load_idx    = '0;
        cmd.drop_en     = 1'b0;
        cmd.drop_idx    = '0;
        cmd.entry.voice = req_reg.voice;
        cmd.entry.prio  = req_reg.prio;
        cmd.entry.cls   = req_reg.cls;

        go = (req_reg.voice != '0) && (req_reg.voice != req_reg.play) && !tok_final.hit;

        case (req_reg.func)
            vpq_pkg::FUNC_SUBMIT:
            begin
                if (go)
                begin
                    if (req_reg.cls == vpq_pkg::CLASS_INTERRUPT)
                    begin
                        cut_next     = (req_reg.play != '0);
                        cmd.load_en  = 1'b1;
                        cmd.load_idx = '0;
                        count_next   = vpq_pkg::count_t'(1);
                    end
                    else if ((req_reg.cls == vpq_pkg::CLASS_STANDARD) &&
                             tok_final.std_found &&
                             (tok_final.std_prio >= req_reg.prio))
                    begin
                        count_next = count_reg;
                    end
                    else
                    begin
                        if ((req_reg.cls == vpq_pkg::CLASS_STANDARD) && tok_final.std_found)
                        begin
                            cmd.drop_en  = 1'b1;
                            cmd.drop_idx = tok_final.std_idx;
                            cnt_after    = count_reg - vpq_pkg::count_t'(1);
                        end
                        else if (count_reg == vpq_pkg::count_t'(vpq_pkg::QueueDepth))
                        begin
                            cmd.drop_en  = 1'b1;
                            cmd.drop_idx = tok_final.worst_idx;
                            cnt_after    = count_reg - vpq_pkg::count_t'(1);
                        end
                        cmd.load_en  = 1'b1;
                        cmd.load_idx = cnt_after[vpq_pkg::IdxW-1:0];
                        count_next   = cnt_after + vpq_pkg::count_t'(1);
                    end
                end
            end
            vpq_pkg::FUNC_NEXT:
            begin
                if (count_reg != '0)
                begin
                    cmd.drop_en  = 1'b1;
                    cmd.drop_idx = tok_final.best_idx;
                    nvalid_next  = 1'b1;
                    nvoice_next  = tok_final.best_voice;
                    count_next   = count_reg - vpq_pkg::count_t'(1);
                end
            end
            vpq_pkg::FUNC_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        // Touch the cells only in the decide cycle
        if (state_reg != ST_DECIDE)
        begin
            cmd.load_en = 1'b0;
            cmd.drop_en = 1'b0;
        end
    end

    // Sequencer, fill count and response registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            cut_reg       <= 1'b0;
            nvalid_reg    <= 1'b0;
            nvoice_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg == ScanLast)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + vpq_pkg::idx_t'(1);
                    end
                end
                ST_DECIDE:
                begin
                    count_reg     <= count_next;
                    cut_reg       <= cut_next;
                    nvalid_reg    <= nvalid_next;
                    nvoice_reg    <= nvoice_next;
                    rsp_valid_reg <= 1'b1;
                    state_reg     <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.cut_playing = cut_reg;
    assign rsp.next_valid  = nvalid_reg;
    assign rsp.next_voice  = nvoice_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vpq_pkg::count_t'(vpq_pkg::QueueDepth))
        else $error("queue fill count exceeds depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DECIDE) |=> $stable(count_reg))
        else $error("fill count changed outside the decide cycle");

    a_rsp_only_resp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (state_reg == ST_RESP))
        else $error("response valid outside the response state");

    a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && nvalid_reg) |-> (nvoice_reg != '0))
        else $error("popped voice is zero");

    a_cut_not_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && cut_reg) |-> !nvalid_reg)
        else $error("cut and pop reported together");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the voice priority queue
// Walks a short table of directed requests, then a long random stream.
// Every accepted request is run through a bench-side queue model. The
// expected response is queued and compared field by field with each
// accepted response. Both channels idle at random, and the response side
// holds off for long stretches so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 6;
    localparam int LIMIT_CYCLES     = 800_000;
    localparam int RANDOM_ITEMS     = 1700;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_GAP          = 18;
    localparam int VOICE_POOL       = 24;

    // Codes not covered by the package
    localparam vpq_pkg::func_t  FUNC_SPARE     = 2'd3;
    localparam vpq_pkg::class_t CLASS_SPARE_LO = 3'd5;
    localparam vpq_pkg::class_t CLASS_SPARE_HI = 3'd7;

    typedef struct packed {
        vpq_pkg::func_t  func;
        vpq_pkg::voice_t voice;
        vpq_pkg::prio_t  prio;
        vpq_pkg::class_t cls;
        vpq_pkg::voice_t playing;
    } req_item_t;

    typedef struct packed {
        logic            cut;
        logic            found;
        vpq_pkg::voice_t voice;
    } voice_reply_t;

    typedef struct packed {
        req_item_t    item;
        logic         typed;
        voice_reply_t reply;
    } directed_row_t;

    localparam voice_reply_t SILENT   = '{1'b0, 1'b0, 10'd0};
    localparam voice_reply_t CUT_ONLY = '{1'b1, 1'b0, 10'd0};

    // Directed requests; typed replies only where they are obvious
    localparam int DIRECTED_COUNT = 25;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // take next on an empty queue right after reset
        '{'{vpq_pkg::FUNC_NEXT,   10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT},
        // unused function code
        '{'{FUNC_SPARE,           10'd1023, 8'd255, CLASS_SPARE_HI,           10'd1023},
          1'b1, SILENT},
        // voice none is ignored
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd0,    8'd255, vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd1023, 8'd255, vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT},
        // already queued
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd1023, 8'd0,   vpq_pkg::CLASS_STANDARD,  10'd0},
          1'b1, SILENT},
        // already playing
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd5,    8'd9,   vpq_pkg::CLASS_QUEUE,     10'd5},
          1'b1, SILENT},
        // standard entry, then a tie that is rejected, then a replacement
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd1,    8'd0,   vpq_pkg::CLASS_STANDARD,  10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd2,    8'd0,   vpq_pkg::CLASS_STANDARD,  10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd3,    8'd10,  vpq_pkg::CLASS_STANDARD,  10'd0},
          1'b0, SILENT},
        // fill the queue with mixed classes, unknown classes among them
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd4,    8'd3,   vpq_pkg::CLASS_QUEUED_IR, 10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd6,    8'd7,   vpq_pkg::CLASS_QUEUE,     10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd7,    8'd200, CLASS_SPARE_HI,           10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd8,    8'd1,   CLASS_SPARE_LO,           10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd9,    8'd50,  vpq_pkg::CLASS_QUEUE,     10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd10,   8'd60,  CLASS_SPARE_LO,           10'd0},
          1'b0, SILENT},
        // full queue: evict on each submit
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd11,   8'd128, vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd12,   8'd128, vpq_pkg::CLASS_QUEUE,     10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_NEXT,   10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b0, SILENT},
        '{'{vpq_pkg::FUNC_NEXT,   10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b0, SILENT},
        // interrupt with and without a playing voice
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd20,   8'd0,   vpq_pkg::CLASS_INTERRUPT, 10'd1023},
          1'b1, CUT_ONLY},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd21,   8'd255, vpq_pkg::CLASS_INTERRUPT, 10'd0},
          1'b1, SILENT},
        '{'{vpq_pkg::FUNC_CLEAR,  10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT},
        '{'{vpq_pkg::FUNC_NEXT,   10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT},
        '{'{vpq_pkg::FUNC_SUBMIT, 10'd1023, 8'd255, vpq_pkg::CLASS_CRITICAL,  10'd1023},
          1'b1, SILENT},
        '{'{vpq_pkg::FUNC_NEXT,   10'd0,    8'd0,   vpq_pkg::CLASS_CRITICAL,  10'd0},
          1'b1, SILENT}
    };

    logic clk;
    logic rst_n;

    vpq_req_if req_ch ();
    vpq_rsp_if rsp_ch ();

    voice_priority_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Bench copy of the queue, oldest entry at index 0
    vpq_pkg::voice_t held_voice [vpq_pkg::QueueDepth];
    vpq_pkg::prio_t  held_prio  [vpq_pkg::QueueDepth];
    vpq_pkg::class_t held_class [vpq_pkg::QueueDepth];
    int              held_count;

    voice_reply_t pending_replies [$];
    int           fault_count;
    bit           sender_brisk;
    bit           sink_brisk;
    bit           sink_hold_pending;

    // Lower standing plays first
    function automatic int standing(input vpq_pkg::class_t c);
        if (c == vpq_pkg::CLASS_CRITICAL)
            return 0;
        if (c == vpq_pkg::CLASS_QUEUED_IR || c == vpq_pkg::CLASS_INTERRUPT)
            return 1;
        if (c == vpq_pkg::CLASS_QUEUE)
            return 2;
        return 3;
    endfunction

    function automatic bit is_held(input vpq_pkg::voice_t v);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_voice[i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Close the gap left by a removed entry
    function automatic void remove_entry(input int idx);
        for (int i = idx; i + 1 < held_count; i++)
        begin
            held_voice[i] = held_voice[i + 1];
            held_prio[i]  = held_prio[i + 1];
            held_class[i] = held_class[i + 1];
        end
        held_count--;
    endfunction

    // Advance the queue copy by one request and return the reply it causes
    function automatic voice_reply_t apply_request(input req_item_t r);
        voice_reply_t reply;
        bit           go;
        int           pick;
        int           s_i;
        int           s_p;
        reply = SILENT;
        case (r.func)
            vpq_pkg::FUNC_SUBMIT:
            begin
                go = (r.voice != '0) && (r.voice != r.playing) && !is_held(r.voice);
                if (go && r.cls == vpq_pkg::CLASS_INTERRUPT)
                begin
                    held_count = 0;
                    reply.cut  = (r.playing != '0);
                end
                if (go && r.cls == vpq_pkg::CLASS_STANDARD)
                begin
                    pick = -1;
                    for (int i = 0; i < held_count && pick < 0; i++)
                    begin
                        if (held_class[i] == vpq_pkg::CLASS_STANDARD)
                            pick = i;
                    end
                    if (pick >= 0)
                    begin
                        if (held_prio[pick] >= r.prio)
                            go = 1'b0;
                        else
                            remove_entry(pick);
                    end
                end
                if (go)
                begin
                    // evict worst class, then lowest priority, then oldest
                    if (held_count >= vpq_pkg::QueueDepth)
                    begin
                        pick = 0;
                        for (int i = 1; i < vpq_pkg::QueueDepth; i++)
                        begin
                            s_i = standing(held_class[i]);
                            s_p = standing(held_class[pick]);
                            if (s_i > s_p || (s_i == s_p && held_prio[i] < held_prio[pick]))
                                pick = i;
                        end
                        remove_entry(pick);
                    end
                    held_voice[held_count] = r.voice;
                    held_prio[held_count]  = r.prio;
                    held_class[held_count] = r.cls;
                    held_count++;
                end
            end
            vpq_pkg::FUNC_NEXT:
            begin
                // pop best class, then highest priority, then oldest
                if (held_count > 0)
                begin
                    pick = 0;
                    for (int i = 1; i < held_count; i++)
                    begin
                        s_i = standing(held_class[i]);
                        s_p = standing(held_class[pick]);
                        if (s_i < s_p || (s_i == s_p && held_prio[i] > held_prio[pick]))
                            pick = i;
                    end
                    reply.found = 1'b1;
                    reply.voice = held_voice[pick];
                    remove_entry(pick);
                end
            end
            vpq_pkg::FUNC_CLEAR:
            begin
                held_count = 0;
            end
            default:
            begin
                reply = SILENT;
            end
        endcase
        return reply;
    endfunction

    // Draw a request: mostly submits from a small voice pool, so that
    // duplicates, replacements and evictions happen often
    function automatic req_item_t random_request();
        req_item_t r;
        int        roll;
        roll = $urandom_range(0, 99);
        if (roll < 62)
            r.func = vpq_pkg::FUNC_SUBMIT;
        else if (roll < 92)
            r.func = vpq_pkg::FUNC_NEXT;
        else if (roll < 96)
            r.func = vpq_pkg::FUNC_CLEAR;
        else
            r.func = FUNC_SPARE;

        roll = $urandom_range(0, 99);
        if (roll < 50)
            r.playing = '0;
        else if (roll < 80)
            r.playing = vpq_pkg::voice_t'($urandom_range(1, VOICE_POOL));
        else
            r.playing = vpq_pkg::voice_t'($urandom_range(0, 1023));

        roll = $urandom_range(0, 99);
        if (roll < 80)
            r.voice = vpq_pkg::voice_t'($urandom_range(1, VOICE_POOL));
        else if (roll < 90)
            r.voice = vpq_pkg::voice_t'($urandom_range(0, 1023));
        else if (roll < 95)
            r.voice = '0;
        else
            r.voice = r.playing;

        if ($urandom_range(0, 9) < 6)
            r.prio = vpq_pkg::prio_t'($urandom_range(0, 255));
        else
            r.prio = vpq_pkg::prio_t'($urandom_range(0, 15));

        roll = $urandom_range(0, 99);
        if (roll < 12)
            r.cls = vpq_pkg::CLASS_CRITICAL;
        else if (roll < 24)
            r.cls = vpq_pkg::CLASS_QUEUED_IR;
        else if (roll < 30)
            r.cls = vpq_pkg::CLASS_INTERRUPT;
        else if (roll < 50)
            r.cls = vpq_pkg::CLASS_QUEUE;
        else if (roll < 80)
            r.cls = vpq_pkg::CLASS_STANDARD;
        else
            r.cls = vpq_pkg::class_t'($urandom_range(CLASS_SPARE_LO, CLASS_SPARE_HI));
        return r;
    endfunction

    // Offer one request, after a random gap unless the sender is brisk, and record its expected reply
    task automatic issue_request(input req_item_t item, input logic typed,
                                 input voice_reply_t typed_reply);
        int           gap;
        voice_reply_t predicted;
        gap = sender_brisk ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.func          <= item.func;
        req_ch.voice_id      <= item.voice;
        req_ch.priority_req  <= item.prio;
        req_ch.control_class <= item.cls;
        req_ch.playing_voice <= item.playing;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_request(item);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the response side at random, with long holds on request
    initial
    begin : response_sink
        int stall;
        int served;
        served = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (served % 40 == 0)
                sink_brisk = ($urandom_range(0, 3) == 0);
            if (sink_hold_pending)
            begin
                stall             = LONG_HOLD_CYCLES;
                sink_hold_pending = 1'b0;
            end
            else if (sink_brisk)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
            served++;
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        voice_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected response: cut_playing %0d next_valid %0d next_voice %0d",
                       rsp_ch.cut_playing, rsp_ch.next_valid, rsp_ch.next_voice);
                fault_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (rsp_ch.cut_playing !== want.cut)
                begin
                    $error("cut_playing: expected %0d, got %0d", want.cut, rsp_ch.cut_playing);
                    fault_count++;
                end
                if (rsp_ch.next_valid !== want.found)
                begin
                    $error("next_valid: expected %0d, got %0d", want.found, rsp_ch.next_valid);
                    fault_count++;
                end
                if (rsp_ch.next_voice !== want.voice)
                begin
                    $error("next_voice: expected %0d, got %0d", want.voice, rsp_ch.next_voice);
                    fault_count++;
                end
            end
        end
    end

    // Hard limit on run length
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, directed table, random stream, drain
    initial
    begin : request_source
        req_item_t item;
        int        issued;
        fault_count       = 0;
        held_count        = 0;
        sender_brisk      = 1'b0;
        sink_brisk        = 1'b0;
        sink_hold_pending = 1'b0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.func          <= vpq_pkg::FUNC_SUBMIT;
        req_ch.voice_id      <= '0;
        req_ch.priority_req  <= '0;
        req_ch.control_class <= vpq_pkg::CLASS_CRITICAL;
        req_ch.playing_voice <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < DIRECTED_COUNT; n++)
        begin
            issue_request(DIRECTED_ROWS[n].item, DIRECTED_ROWS[n].typed,
                          DIRECTED_ROWS[n].reply);
        end

        // random stream; long response holds back up the request side
        for (issued = 0; issued < RANDOM_ITEMS; issued++)
        begin
            if (issued == 150 || issued == 1200)
                sink_hold_pending = 1'b1;
            if (issued % 40 == 0)
                sender_brisk = ($urandom_range(0, 3) == 0);
            item = random_request();
            issue_request(item, 1'b0, SILENT);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // drain outstanding responses, then let the pipeline settle
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (vpq_pkg::QueueDepth + 4) @(posedge clk);

        if (fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/vpq_pkg.sv
rtl/vpq_if.sv
rtl/vpq_cell.sv
rtl/voice_priority_queue_top.sv
tb/sv/tb_top.sv
